/* design/dfa_word_acceptor_defines.svh */
// Assertion macros for the design files; only the table engine includes them.
`ifndef DFA_WORD_ACCEPTOR_DEFINES_SVH
`define DFA_WORD_ACCEPTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DWA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dwa_pkg.sv */
package dwa_pkg;

    localparam int DEF_NUM_STATES  = 16;
    localparam int DEF_SYMBOL_BITS = 8;

    localparam int STATE_W    = 4;
    localparam int SYMBOL_W   = 8;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    // Wide enough to hold the largest state count.
    localparam int RANGE_W    = 9;

    localparam int OP_QUEUE_DEPTH  = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK    = 2'd1;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SYMBOL = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_REJECT = 2'd1,
        VERDICT_DEAD   = 2'd2
    } t_verdict;

    typedef struct packed {
        t_cmd                kind;
        logic [STATE_W-1:0]  state;
        logic [SYMBOL_W-1:0] symbol;
        logic [STATE_W-1:0]  target;
        logic                entry_valid;
        logic                last;
    } t_op;

    typedef struct packed {
        t_verdict           verdict;
        logic [STATE_W-1:0] end_state;
    } t_result;

    function automatic logic state_in_range(input logic [STATE_W-1:0] state,
                                            input int num_states);
        return {{(RANGE_W-STATE_W){1'b0}}, state} < RANGE_W'(num_states);
    endfunction

endpackage

/* design/dfa_word_acceptor.sv */
// Table-driven DFA recognizer. Words arrive one symbol per input transaction; a
// transaction with cmd 0 instead writes one transition table entry (next state, or
// "no transition") for a state and symbol pair. Each word starts at the initial_state
// register, and the transaction flagged last produces one result transaction: accepted,
// rejected, or dead when a step found no transition or no table row, with the end state.
// Table writes and non-final symbols produce no result. After reset the whole table
// (NUM_STATES * 2**SYMBOL_BITS entries, 4096 at the defaults) is cleared one entry per
// cycle, and full stays high until clearing is done; configuration writes are taken at
// any time. Each symbol takes two back-end steps, the registered table read and then
// the state update from it, since the next read address depends on that state; a
// table write takes only the first step. A two-entry operation queue sits between
// the input decoder and the table engine, and a two-entry result queue on the output,
// so input keeps flowing while a result waits to be popped, until the queues fill.
module dfa_word_acceptor
    import dwa_pkg::*;
#(
    parameter int NUM_STATES  = DEF_NUM_STATES,
    parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input side
    input  logic                  push,
    output logic                  full,
    input  logic                  i_cmd,
    input  logic [STATE_W-1:0]    i_source_state,
    input  logic [SYMBOL_W-1:0]   i_symbol,
    input  logic [STATE_W-1:0]    i_target_state,
    input  logic                  i_entry_valid,
    input  logic                  i_last,
    // Result side
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_verdict,
    output logic [STATE_W-1:0]    o_end_state,
    // Configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [STATE_W-1:0] r_initial_state;
    logic [MASK_W-1:0]  r_final_mask;

    logic    clearing;
    logic    opq_push;
    t_op     opq_in;
    logic    opq_full;
    logic    opq_empty;
    logic    opq_pop;
    logic [$bits(t_op)-1:0] opq_out_bits;
    logic    resq_push;
    t_result resq_in;
    logic    resq_full;
    logic [$bits(t_result)-1:0] resq_out_bits;
    t_result resq_out;

    // Configuration registers. Indexes past the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_state <= '0;
            r_final_mask    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INITIAL_STATE: r_initial_state <= i_cfg_data[STATE_W-1:0];
                CFG_FINAL_MASK:    r_final_mask    <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: registers and decodes each input transaction, drops writes that
    // name states outside the table, and holds off input while the table clears.
    dwa_front #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_hold         (clearing),
        .i_cmd          (i_cmd),
        .i_source_state (i_source_state),
        .i_symbol       (i_symbol),
        .i_target_state (i_target_state),
        .i_entry_valid  (i_entry_valid),
        .i_last         (i_last),
        .i_q_full       (opq_full),
        .o_full         (full),
        .o_q_push       (opq_push),
        .o_q_op         (opq_in)
    );

    // Decoupling queue between decode and the table engine.
    dwa_queue #(
        .WIDTH ($bits(t_op)),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (opq_push),
        .i_data  (opq_in),
        .i_pop   (opq_pop),
        .o_data  (opq_out_bits),
        .o_full  (opq_full),
        .o_empty (opq_empty)
    );

    // Back end: owns the transition table, walks words and forms verdicts.
    dwa_engine #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_empty      (opq_empty),
        .i_op            (t_op'(opq_out_bits)),
        .i_initial_state (r_initial_state),
        .i_final_mask    (r_final_mask),
        .i_res_full      (resq_full),
        .o_op_pop        (opq_pop),
        .o_res_push      (resq_push),
        .o_res           (resq_in),
        .o_clearing      (clearing)
    );

    // Result queue; its head is what the consumer sees while empty is low.
    dwa_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (resq_push),
        .i_data  (resq_in),
        .i_pop   (pop),
        .o_data  (resq_out_bits),
        .o_full  (resq_full),
        .o_empty (empty)
    );

    assign resq_out    = t_result'(resq_out_bits);
    assign o_verdict   = resq_out.verdict;
    assign o_end_state = resq_out.end_state;

endmodule

/* design/dwa_queue.sv */
module dwa_queue
    import dwa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* design/dwa_front.sv */
module dwa_front
    import dwa_pkg::*;
#(
    parameter int NUM_STATES  = DEF_NUM_STATES,
    parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_hold,
    input  logic                i_cmd,
    input  logic [STATE_W-1:0]  i_source_state,
    input  logic [SYMBOL_W-1:0] i_symbol,
    input  logic [STATE_W-1:0]  i_target_state,
    input  logic                i_entry_valid,
    input  logic                i_last,
    input  logic                i_q_full,
    output logic                o_full,
    output logic                o_q_push,
    output t_op                 o_q_op
);

    localparam logic [SYMBOL_W-1:0] SYM_MASK = SYMBOL_W'((1 << SYMBOL_BITS) - 1);

    logic r_valid, n_valid;
    t_op  r_op;
    t_op  dec_op;
    logic accept;
    logic keep;

    // Decode the incoming item; writes naming a state outside the table are dropped.
    always_comb begin
        dec_op.kind        = t_cmd'(i_cmd);
        dec_op.state       = i_source_state;
        dec_op.symbol      = i_symbol & SYM_MASK;
        dec_op.target      = i_entry_valid ? i_target_state : '0;
        dec_op.entry_valid = i_entry_valid;
        dec_op.last        = i_last;
        keep = (dec_op.kind == CMD_SYMBOL)
             || (state_in_range(i_source_state, NUM_STATES)
                 && state_in_range(i_target_state, NUM_STATES));
    end

    assign o_full   = i_hold | (r_valid & i_q_full);
    assign accept   = i_push & ~o_full;
    assign o_q_push = r_valid & ~i_q_full;
    assign o_q_op   = r_op;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = keep;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= dec_op;
        end
    end

endmodule

/* design/dwa_engine.sv */
`include "dfa_word_acceptor_defines.svh"

module dwa_engine
    import dwa_pkg::*;
#(
    parameter int NUM_STATES  = DEF_NUM_STATES,
    parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_empty,
    input  t_op                i_op,
    input  logic [STATE_W-1:0] i_initial_state,
    input  logic [MASK_W-1:0]  i_final_mask,
    input  logic               i_res_full,
    output logic               o_op_pop,
    output logic               o_res_push,
    output t_result            o_res,
    output logic               o_clearing
);

    localparam int SYM_COUNT   = 1 << SYMBOL_BITS;
    localparam int TABLE_DEPTH = NUM_STATES * SYM_COUNT;
    localparam int ROW_BITS    = $clog2(NUM_STATES);
    localparam int ADDR_W      = ROW_BITS + SYMBOL_BITS;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] next;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } t_eng_state;

    t_entry             r_table [TABLE_DEPTH];
    t_entry             r_rd_data;
    t_eng_state         r_state, n_state;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [STATE_W-1:0] r_cur, n_cur;
    logic               r_dead, n_dead;
    logic               r_at_start, n_at_start;
    logic               r_last, n_last;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_entry             mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic [STATE_W-1:0] start_state;
    logic               start_dead;
    logic               row_ok;
    logic               step_dead;
    logic [STATE_W-1:0] step_cur;

    assign start_state = r_at_start ? i_initial_state : r_cur;
    assign start_dead  = r_at_start ? 1'b0 : r_dead;
    assign row_ok      = state_in_range(start_state, NUM_STATES);
    assign mem_raddr   = {ROW_BITS'(start_state), SYMBOL_BITS'(i_op.symbol)};

    assign step_dead = r_dead | ~r_rd_data.valid;
    assign step_cur  = step_dead ? r_cur : r_rd_data.next;

    always_comb begin
        o_res.end_state = step_cur;
        if (step_dead) begin
            o_res.verdict = VERDICT_DEAD;
        end else if (i_final_mask[step_cur]) begin
            o_res.verdict = VERDICT_ACCEPT;
        end else begin
            o_res.verdict = VERDICT_REJECT;
        end
    end

    assign o_clearing = (r_state == ST_CLEAR);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cur      = r_cur;
        n_dead     = r_dead;
        n_at_start = r_at_start;
        n_last     = r_last;
        o_op_pop   = 1'b0;
        o_res_push = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_clr_addr;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_op_empty) begin
                    o_op_pop = 1'b1;
                    if (i_op.kind == CMD_WRITE) begin
                        mem_we          = 1'b1;
                        mem_waddr       = {ROW_BITS'(i_op.state), SYMBOL_BITS'(i_op.symbol)};
                        mem_wdata.valid = i_op.entry_valid;
                        mem_wdata.next  = i_op.target;
                    end else begin
                        // A dead word or an unknown start state skips the table read.
                        n_cur      = start_state;
                        n_dead     = start_dead | ~row_ok;
                        n_at_start = 1'b0;
                        n_last     = i_op.last;
                        mem_re     = ~start_dead & row_ok;
                        n_state    = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                if (!r_last) begin
                    n_cur   = step_cur;
                    n_dead  = step_dead;
                    n_state = ST_IDLE;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_cur      = step_cur;
                    n_dead     = 1'b0;
                    n_at_start = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_cur      <= '0;
            r_dead     <= 1'b0;
            r_at_start <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_cur      <= n_cur;
            r_dead     <= n_dead;
            r_at_start <= n_at_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_table[mem_raddr];
        end
    end

    `DWA_ASSERT_NOW(a_no_pop_while_clearing, i_clk, i_rst_n, (r_state == ST_CLEAR), !o_op_pop, "operation taken during table clear")
    `DWA_ASSERT_NOW(a_push_only_with_room, i_clk, i_rst_n, o_res_push, ((r_state == ST_LOOKUP) && !i_res_full && r_last), "result pushed outside a finished last symbol")
    `DWA_ASSERT_NEXT(a_read_then_lookup, i_clk, i_rst_n, mem_re, (r_state == ST_LOOKUP), "table read not followed by state update")
    `DWA_ASSERT_NEXT(a_word_restarts, i_clk, i_rst_n, o_res_push, (r_at_start && !r_dead), "word state not rewound after its result")

endmodule

/* tb/sv/dfa_word_acceptor_test.sv */
`timescale 1ns / 100ps

module dfa_word_acceptor_test;
    import dwa_pkg::*;

    // Register indexes past the end of the register list; writes there must
    // have no effect.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // The table is cleared one entry per cycle after reset, so the first push
    // waits for the whole clearing pass. The limit leaves a wide margin above
    // that and above the long receiver hold-off.
    localparam int WATCHDOG_LIMIT = 20000;
    // Cycles allowed for the block to finish transactions that produce no
    // result: the queued operations and the front and engine registers.
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic                  i_cmd;
    logic [STATE_W-1:0]    i_source_state;
    logic [SYMBOL_W-1:0]   i_symbol;
    logic [STATE_W-1:0]    i_target_state;
    logic                  i_entry_valid;
    logic                  i_last;
    logic                  empty;
    logic                  pop;
    logic [1:0]            o_verdict;
    logic [STATE_W-1:0]    o_end_state;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dfa_word_acceptor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_source_state (i_source_state),
        .i_symbol       (i_symbol),
        .i_target_state (i_target_state),
        .i_entry_valid  (i_entry_valid),
        .i_last         (i_last),
        .empty          (empty),
        .pop            (pop),
        .o_verdict      (o_verdict),
        .o_end_state    (o_end_state),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // Behavioral copy of the automaton: transition table, walk state and the
    // two registers as the block should currently hold them.
    logic               arc_valid [16][256];
    logic [STATE_W-1:0] arc_next  [16][256];
    logic [STATE_W-1:0] walk_state;
    logic               walk_dead;
    logic               walk_at_start;
    logic [STATE_W-1:0] start_state;
    logic [MASK_W-1:0]  accept_mask;

    // Verdicts of finished words, oldest first, waiting to be popped.
    t_result pending_verdicts[$];

    int mismatch_count;
    int idle_cycles;
    // When set, both sides stop drawing idle cycles.
    bit burst;
    // Set by a test to make the result side stop popping for that many cycles.
    int hold_request;
    // Symbols that the current random phase builds its table and words from.
    logic [SYMBOL_W-1:0] phase_symbols [4];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reset state of the behavioral copy. The table starts with no transition
    // anywhere, the same as the block after its clearing pass.
    function automatic void reset_automaton();
        for (int s = 0; s < 16; s++) begin
            for (int c = 0; c < 256; c++) begin
                arc_valid[s][c] = 1'b0;
                arc_next[s][c]  = '0;
            end
        end
        walk_state    = '0;
        walk_dead     = 1'b0;
        walk_at_start = 1'b1;
        start_state   = '0;
        accept_mask   = '0;
    endfunction

    // Apply one accepted input transaction to the behavioral copy. A table
    // write only edits the table. A symbol advances the walk, and the last
    // symbol of a word queues the verdict the block must report.
    function automatic void walk_automaton(input t_op op);
        t_result verdict;
        if (op.kind == CMD_WRITE) begin
            arc_valid[op.state][op.symbol] = op.entry_valid;
            arc_next[op.state][op.symbol]  = op.entry_valid ? op.target : '0;
            return;
        end
        if (walk_at_start) begin
            walk_state    = start_state;
            walk_dead     = 1'b0;
            walk_at_start = 1'b0;
        end
        // Once a word is dead its state stays where the walk died.
        if (!walk_dead) begin
            if (arc_valid[walk_state][op.symbol]) begin
                walk_state = arc_next[walk_state][op.symbol];
            end else begin
                walk_dead = 1'b1;
            end
        end
        if (op.last) begin
            if (walk_dead) begin
                verdict.verdict = VERDICT_DEAD;
            end else if (accept_mask[walk_state]) begin
                verdict.verdict = VERDICT_ACCEPT;
            end else begin
                verdict.verdict = VERDICT_REJECT;
            end
            verdict.end_state = walk_state;
            pending_verdicts = {pending_verdicts, verdict};
            walk_at_start = 1'b1;
            walk_dead     = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [3:0] got,
                                   input logic [3:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Table write transaction. The last flag means nothing for a write, so
    // it is random.
    function automatic t_op table_op(input logic [STATE_W-1:0] src,
                                     input logic [SYMBOL_W-1:0] sym,
                                     input logic [STATE_W-1:0] tgt,
                                     input logic valid);
        t_op op;
        op.kind        = CMD_WRITE;
        op.state       = src;
        op.symbol      = sym;
        op.target      = tgt;
        op.entry_valid = valid;
        op.last        = 1'($urandom_range(0, 1));
        return op;
    endfunction

    // Symbol transaction. The table fields are ignored by the block, so they
    // carry random values.
    function automatic t_op symbol_op(input logic [SYMBOL_W-1:0] sym, input logic last);
        t_op op;
        op.kind        = CMD_SYMBOL;
        op.state       = 4'($urandom_range(0, 15));
        op.symbol      = sym;
        op.target      = 4'($urandom_range(0, 15));
        op.entry_valid = 1'($urandom_range(0, 1));
        op.last        = last;
        return op;
    endfunction

    // Mostly a symbol of the phase, so that walks stay on written entries,
    // and now and then any byte at all.
    function automatic logic [SYMBOL_W-1:0] pick_symbol();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return phase_symbols[$urandom_range(0, 3)];
    endfunction

    // Offer one input transaction and wait until the block takes it. With no
    // idle cycles drawn, push stays high from the previous transaction.
    task automatic send_op(input t_op op);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_cmd          <= op.kind;
        i_source_state <= op.state;
        i_symbol       <= op.symbol;
        i_target_state <= op.target;
        i_entry_valid  <= op.entry_valid;
        i_last         <= op.last;
        do @(posedge i_clk); while (full);
        walk_automaton(op);
    endtask

    // Stop pushing and wait until every expected verdict has been popped,
    // then give the block time to finish writes and unfinished words.
    task automatic settle();
        push <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; the enable drops again after each write so that two
    // writes in a row never lower and raise it at the same edge.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_INITIAL_STATE: start_state = data[STATE_W-1:0];
            CFG_FINAL_MASK:    accept_mask = data;
            default: ;
        endcase
    endtask

    // After reset no transition exists, so any word dies at the initial
    // state right away.
    task automatic test_cleared_table();
        send_op(symbol_op(8'h5A, 1'b1));
        settle();
    endtask

    // Hand-built automaton:
    //   15 --00--> 0, 0 --FF--> 15, 15 --80--> 7, and 0 --41 marked with no
    //   transition. States 0 and 15 accept.
    task automatic test_directed_walks();
        // Upper data bits are dropped for the four-bit register.
        write_register(CFG_INITIAL_STATE, 16'hA5AF);
        write_register(CFG_FINAL_MASK, 16'h8001);
        // Writes past the register list must change nothing.
        write_register(CFG_SPARE_LO, 16'hFFFF);
        write_register(CFG_SPARE_HI, 16'h0000);

        send_op(table_op(4'd15, 8'h00, 4'd0, 1'b1));
        send_op(table_op(4'd0, 8'hFF, 4'd15, 1'b1));
        send_op(table_op(4'd0, 8'h41, 4'd9, 1'b0));
        send_op(table_op(4'd15, 8'h80, 4'd7, 1'b1));

        // Single symbol word that ends in an accepting state.
        send_op(symbol_op(8'h00, 1'b1));
        // Two steps, back to the accepting initial state.
        send_op(symbol_op(8'h00, 1'b0));
        send_op(symbol_op(8'hFF, 1'b1));
        // Ends in a state that is not accepting.
        send_op(symbol_op(8'h80, 1'b1));
        // The last symbol hits an entry marked with no transition.
        send_op(symbol_op(8'h00, 1'b0));
        send_op(symbol_op(8'h41, 1'b1));
        // The word dies in the middle and stays dead although the last symbol
        // would have a valid transition from the state where it died.
        send_op(symbol_op(8'h00, 1'b0));
        send_op(symbol_op(8'h41, 1'b0));
        send_op(symbol_op(8'h00, 1'b0));
        send_op(symbol_op(8'hFF, 1'b1));
        // A table write in the middle of a word leaves the walk alone and is
        // used by the next symbol.
        send_op(symbol_op(8'h00, 1'b0));
        send_op(table_op(4'd0, 8'h42, 4'd5, 1'b1));
        send_op(symbol_op(8'h42, 1'b1));
        // Overwriting a valid entry with no transition kills the next walk.
        send_op(table_op(4'd15, 8'h00, 4'd3, 1'b0));
        send_op(symbol_op(8'h00, 1'b1));
        settle();
    endtask

    // Random phases, each with its own register settings and symbol set.
    // Every phase first seeds the table with entries over its symbols so that
    // most words walk several live steps, then mixes table writes into the
    // word stream. Some phases run with no idle cycles on either side.
    task automatic test_random_words();
        logic [CFG_DATA_W-1:0] init_data;
        logic [CFG_DATA_W-1:0] mask_data;
        t_op op;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            burst = (phase == 2) || (phase == 5);
            case (phase)
                0: begin
                    init_data = 16'h0000;
                    mask_data = 16'hFFFF;
                end
                1: begin
                    init_data = 16'hFFFF;
                    mask_data = 16'h0000;
                end
                3: begin
                    init_data = 16'($urandom_range(0, 65535));
                    mask_data = 16'h0001 << $urandom_range(0, 15);
                end
                default: begin
                    init_data = 16'($urandom_range(0, 65535));
                    mask_data = 16'($urandom_range(0, 65535));
                end
            endcase
            write_register(CFG_INITIAL_STATE, init_data);
            write_register(CFG_FINAL_MASK, mask_data);

            for (int k = 0; k < 4; k++) begin
                phase_symbols[k] = 8'($urandom_range(0, 255));
            end
            // The extreme bytes get a phase of their own.
            if (phase == 0) begin
                phase_symbols[0] = 8'h00;
                phase_symbols[1] = 8'hFF;
            end

            repeat (30) begin
                send_op(table_op(4'($urandom_range(0, 15)), pick_symbol(),
                                 4'($urandom_range(0, 15)), $urandom_range(0, 7) != 0));
            end
            repeat (PHASE_ITEMS - 30) begin
                if ($urandom_range(0, 4) == 0) begin
                    op = table_op(4'($urandom_range(0, 15)), pick_symbol(),
                                  4'($urandom_range(0, 15)), $urandom_range(0, 5) != 0);
                end else begin
                    op = symbol_op(pick_symbol(), $urandom_range(0, 2) == 0);
                end
                send_op(op);
            end
            // Close an open word so that the next register change happens
            // between words.
            if (!walk_at_start) begin
                send_op(symbol_op(pick_symbol(), 1'b1));
            end
            settle();
        end
        burst = 1'b0;
    endtask

    // The result side stops popping for a long stretch while single-symbol
    // words keep arriving back to back, so both internal queues fill and the
    // block must hold full high until results drain again.
    task automatic test_full_backpressure();
        burst = 1'b1;
        send_op(table_op(start_state, 8'h3C, 4'd6, 1'b1));
        hold_request = HOLD_OFF_CYCLES;
        repeat (40) begin
            send_op(symbol_op(8'h3C, 1'b1));
        end
        burst = 1'b0;
        settle();
    endtask

    // Result side: draws idle cycles before each result, and serves a long
    // hold-off when a test asks for one.
    initial begin
        int wait_cycles;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                pop <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end
            wait_cycles = burst ? 0 : $urandom_range(0, 8);
            if (wait_cycles != 0) begin
                pop <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // Every popped result must match the oldest expected verdict.
    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with no word pending, verdict", {2'b00, o_verdict},
                                4'h0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_verdict !== want.verdict) begin
                    report_mismatch("verdict", {2'b00, o_verdict}, {2'b00, want.verdict});
                end
                if (o_end_state !== want.end_state) begin
                    report_mismatch("end_state", o_end_state, want.end_state);
                end
            end
        end
    end

    // Ends the run when no transaction has moved on either side for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        idle_cycles    = 0;
        burst          = 1'b0;
        hold_request   = 0;
        reset_automaton();

        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_cmd          <= CMD_WRITE;
        i_source_state <= '0;
        i_symbol       <= '0;
        i_target_state <= '0;
        i_entry_valid  <= 1'b0;
        i_last         <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_INITIAL_STATE;
        i_cfg_data     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_table();
        test_directed_walks();
        test_random_words();
        test_full_backpressure();

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
